// ===== design/sorted_event_queue_assert.svh =====
// Assertion macros shared by the sorted event queue modules.
// Every module that includes this file must have a clock named clk and a reset named rst_n.
`ifndef SORTED_EVENT_QUEUE_ASSERT_SVH
`define SORTED_EVENT_QUEUE_ASSERT_SVH

// Checks a property at every clock edge while the block is out of reset.
`define SEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/seq_pkg.sv =====
// Shared types, constants and helpers for the sorted event queue.
// Used by the cell, the output buffer and the top level; depends on nothing.
package seq_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [3:0]  kind;
        logic [15:0] mobile;
        logic [7:0]  sw;
        logic [15:0] handle;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_MARK,
        CELL_SWEEP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
        entry_t   item;
    } cell_ctl_t;

    typedef struct packed {
        logic        popped_valid;
        logic [31:0] out_time;
        logic [3:0]  out_kind;
        logic [15:0] out_mobile;
        logic [7:0]  out_switch;
        logic [15:0] out_handle;
        logic [6:0]  entry_count;
        logic        list_empty;
        logic        insert_dropped;
        logic [6:0]  removed_count;
    } result_t;

    // Fits a count into the 7-bit result fields, truncating or zero extending.
    function automatic logic [6:0] cnt_to_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+6:0] w;
        w = {7'd0, v};
        return w[6:0];
    endfunction

endpackage

// ===== design/seq_cell.sv =====
// One storage cell of the sorted event queue chain.
// Depends on seq_pkg for the entry and control types.
module seq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  seq_pkg::cell_ctl_t ctl,
    input  logic               occ,
    input  logic               parity,
    input  logic               prev_le,
    input  logic               prev_hole,
    input  seq_pkg::entry_t    prev_entry,
    input  logic               next_hole,
    input  logic               next_tok,
    input  seq_pkg::entry_t    next_entry,
    output seq_pkg::entry_t    entry,
    output logic               le,
    output logic               hole,
    output logic               tok
);
    import seq_pkg::*;

    entry_t entry_reg, entry_next;
    logic   hole_reg, hole_next;
    logic   tok_reg, tok_next;
    logic   match;

    assign le    = occ && (entry_reg.ev_time <= ctl.item.ev_time);
    assign match = occ && (entry_reg.ev_time == ctl.item.ev_time)
                   && (entry_reg.kind == ctl.item.kind)
                   && (entry_reg.mobile == ctl.item.mobile)
                   && (entry_reg.sw == ctl.item.sw);

    always_comb
    begin
        entry_next = entry_reg;
        hole_next  = hole_reg;
        tok_next   = tok_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                // Entries at or before the new time stay; the first later one takes the item, later ones shift up.
                if (!le)
                begin
                    entry_next = prev_le ? ctl.item : prev_entry;
                end
            end
            CELL_POP:
            begin
                entry_next = next_entry;
            end
            CELL_MARK:
            begin
                hole_next = match;
                tok_next  = match;
            end
            CELL_SWEEP:
            begin
                tok_next = next_tok;
                if (parity == ctl.phase)
                begin
                    if (hole_reg && !next_hole)
                    begin
                        entry_next = next_entry;
                        hole_next  = 1'b0;
                    end
                end
                else
                begin
                    if (prev_hole && !hole_reg)
                    begin
                        entry_next = prev_entry;
                        hole_next  = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_reg <= 1'b0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            hole_reg <= hole_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hole  = hole_reg;
    assign tok   = tok_reg;

endmodule

// ===== design/seq_obuf.sv =====
// Two-slot output buffer: an output register backed by a skid register.
// Depends on seq_pkg for the result type and on the shared assertion macros.
module seq_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  seq_pkg::result_t push_data,
    output logic             skid_full,
    output logic             out_valid,
    input  logic             out_stall,
    output seq_pkg::result_t out_data
);
    import seq_pkg::*;
    `include "sorted_event_queue_assert.svh"

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    take;

    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SEQ_ASSERT(a_no_overflow, !(push && out_valid_reg && skid_valid_reg && !take), "result pushed into a full buffer")

endmodule

// ===== design/sorted_event_queue.sv =====
// Sorted event queue top level: controller, cell chain and output buffer.
// Depends on seq_pkg, seq_cell, seq_obuf and the shared assertion macros.
//
// Use: an operation beat enters on in_valid/in_stall with func and the event fields;
// each beat gives exactly one result beat on out_valid/out_stall. Insert keeps the
// queue ordered by time with equal times in arrival order, pop returns the earliest
// event, remove deletes every entry whose time, kind, mobile and switch all match.
// Every result carries the entry count and the empty flag after the operation.
//
// Timing: insert, pop and the unused code finish in the cycle they are accepted, as
// every cell compares against the broadcast event and loads from itself or a
// neighbor; the result is registered in the output buffer and a new beat can follow at once.
// A remove first marks the matching cells in the cycle it is accepted, then DEPTH
// odd-even exchange rounds move the deleted slots to the tail of the chain while a
// token line shifts the match marks into the removal counter.
// The input is stalled during that sweep.
//
// Reset clears the count, so the queue starts empty; stored entries need no clearing.
// The input stalls while reset is held. When the receiver stalls, one finished result
// waits in the output register and the next one in a skid register; the input stalls
// only once the skid register is filled.
module sorted_event_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] event_time,
    input  logic [3:0]  event_kind,
    input  logic [15:0] mobile_id,
    input  logic [7:0]  switch_id,
    input  logic [15:0] event_handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        popped_valid,
    output logic [31:0] out_time,
    output logic [3:0]  out_kind,
    output logic [15:0] out_mobile,
    output logic [7:0]  out_switch,
    output logic [15:0] out_handle,
    output logic [6:0]  entry_count,
    output logic        list_empty,
    output logic        insert_dropped,
    output logic [6:0]  removed_count
);
    import seq_pkg::*;
    `include "sorted_event_queue_assert.svh"

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] sweep_cnt_reg;
    logic [CNT_W-1:0] rem_reg, rem_total;

    cell_ctl_t ctl;
    entry_t    item;
    result_t   res, out_res;
    logic      push, skid_full, in_accept, start_sweep, sweep_last, full;

    entry_t entry_w [DEPTH];
    logic   le_w    [DEPTH];
    logic   hole_w  [DEPTH];
    logic   tok_w   [DEPTH];
    logic   occ_w   [DEPTH];

    assign in_stall  = !rst_n || (state_reg != ST_IDLE) || skid_full;
    assign in_accept = in_valid && !in_stall;

    assign item.ev_time = event_time;
    assign item.kind    = event_kind;
    assign item.mobile  = mobile_id;
    assign item.sw      = switch_id;
    assign item.handle  = event_handle;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign rem_total  = rem_reg + CNT_W'(tok_w[0]);
    assign sweep_last = (sweep_cnt_reg == IDX_W'(DEPTH - 1));

    // The cell chain. Cell 0 sees a neighbor that is always at or before the new
    // time; the last cell sees a deleted slot beyond it, so a sweep never pulls in garbage.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] POS = CNT_W'(i);
        logic   prev_le_i, prev_hole_i, next_hole_i, next_tok_i;
        entry_t prev_entry_i, next_entry_i;

        assign occ_w[i] = (POS < count_reg);

        if (i == 0)
        begin : g_first
            assign prev_le_i    = 1'b1;
            assign prev_hole_i  = 1'b0;
            assign prev_entry_i = item;
        end
        else
        begin : g_mid_prev
            assign prev_le_i    = le_w[i-1];
            assign prev_hole_i  = hole_w[i-1];
            assign prev_entry_i = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_hole_i  = 1'b1;
            assign next_tok_i   = 1'b0;
            assign next_entry_i = item;
        end
        else
        begin : g_mid_next
            assign next_hole_i  = hole_w[i+1];
            assign next_tok_i   = tok_w[i+1];
            assign next_entry_i = entry_w[i+1];
        end

        seq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .occ        (occ_w[i]),
            .parity     (1'(i % 2)),
            .prev_le    (prev_le_i),
            .prev_hole  (prev_hole_i),
            .prev_entry (prev_entry_i),
            .next_hole  (next_hole_i),
            .next_tok   (next_tok_i),
            .next_entry (next_entry_i),
            .entry      (entry_w[i]),
            .le         (le_w[i]),
            .hole       (hole_w[i]),
            .tok        (tok_w[i])
        );
    end

    // Operation decode and result assembly.
    always_comb
    begin
        ctl.op      = CELL_HOLD;
        ctl.phase   = sweep_cnt_reg[0];
        ctl.item    = item;
        res         = '0;
        push        = 1'b0;
        start_sweep = 1'b0;
        count_next  = count_reg;
        if (state_reg == ST_SWEEP)
        begin
            ctl.op = CELL_SWEEP;
            if (sweep_last)
            begin
                push              = 1'b1;
                count_next        = count_reg - rem_total;
                res.removed_count = cnt_to_field(rem_total);
            end
        end
        else if (in_accept)
        begin
            unique case (func)
                FUNC_INSERT:
                begin
                    push = 1'b1;
                    if (full)
                    begin
                        res.insert_dropped = 1'b1;
                    end
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_POP:
                begin
                    push = 1'b1;
                    if (count_reg != '0)
                    begin
                        ctl.op           = CELL_POP;
                        count_next       = count_reg - CNT_W'(1);
                        res.popped_valid = 1'b1;
                        res.out_time     = entry_w[0].ev_time;
                        res.out_kind     = entry_w[0].kind;
                        res.out_mobile   = entry_w[0].mobile;
                        res.out_switch   = entry_w[0].sw;
                        res.out_handle   = entry_w[0].handle;
                    end
                end
                FUNC_REMOVE:
                begin
                    ctl.op      = CELL_MARK;
                    start_sweep = 1'b1;
                end
                default:
                begin
                    push = 1'b1;
                end
            endcase
        end
        res.entry_count = cnt_to_field(count_next);
        res.list_empty  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sweep_cnt_reg <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            count_reg <= count_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_sweep)
                    begin
                        state_reg     <= ST_SWEEP;
                        sweep_cnt_reg <= '0;
                        rem_reg       <= '0;
                    end
                end
                ST_SWEEP:
                begin
                    rem_reg       <= rem_total;
                    sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
                    if (sweep_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    seq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .skid_full (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign popped_valid   = out_res.popped_valid;
    assign out_time       = out_res.out_time;
    assign out_kind       = out_res.out_kind;
    assign out_mobile     = out_res.out_mobile;
    assign out_switch     = out_res.out_switch;
    assign out_handle     = out_res.out_handle;
    assign entry_count    = out_res.entry_count;
    assign list_empty     = out_res.list_empty;
    assign insert_dropped = out_res.insert_dropped;
    assign removed_count  = out_res.removed_count;

    `SEQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `SEQ_ASSERT(a_sweep_stalls, (state_reg != ST_SWEEP) || in_stall, "input accepted during sweep")
    `SEQ_ASSERT_NEXT(a_pop_count, in_accept && (func == FUNC_POP) && (count_reg != '0), count_reg == $past(count_reg) - CNT_W'(1), "pop did not decrement count")

endmodule

// ===== dv/tb_sorted_event_queue.sv =====
// Self-checking testbench for sorted_event_queue: directed table, then random phases.
// Holds its own ordered-queue predictor; depends on seq_pkg and the RTL under design/.
module tb_sorted_event_queue;

    import seq_pkg::*;

    // The unused operation code; the block must answer it with a result that
    // carries only the count and the empty flag.
    localparam logic [1:0] FUNC_NOP = 2'd3;

    // Longest stretch without any accepted beat that a correct block can show:
    // a remove sweep, plus sender gaps and receiver stalls.
    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_BEATS = 1400;
    localparam int TAIL_CYCLES = 80;

    typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN, MODE_PURGE} phase_mode_t;

    typedef struct packed {
        logic [1:0] fn;
        entry_t     ev;
        logic       typed;
        result_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] event_time;
    logic [3:0]  event_kind;
    logic [15:0] mobile_id;
    logic [7:0]  switch_id;
    logic [15:0] event_handle;
    logic        out_valid;
    logic        out_stall;
    logic        popped_valid;
    logic [31:0] out_time;
    logic [3:0]  out_kind;
    logic [15:0] out_mobile;
    logic [7:0]  out_switch;
    logic [15:0] out_handle;
    logic [6:0]  entry_count;
    logic        list_empty;
    logic        insert_dropped;
    logic [6:0]  removed_count;

    // Predictor state: the stored events, earliest first, and the results that
    // the block still owes, oldest first.
    entry_t  sched_q[$];
    result_t pending_results[$];
    dir_row_t dir_rows[$];

    // Small pools of field values so that equal times and repeated keys occur
    // often enough to exercise arrival order and multi-entry removes.
    logic [31:0] time_pool[4];
    logic [15:0] mob_pool[2];
    logic [7:0]  sw_pool[2];

    int  mismatches = 0;
    int  idle_cycles = 0;
    // When set, both sides run back to back without gaps or stalls.
    bit  quiet = 1'b0;

    sorted_event_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .event_time     (event_time),
        .event_kind     (event_kind),
        .mobile_id      (mobile_id),
        .switch_id      (switch_id),
        .event_handle   (event_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .popped_valid   (popped_valid),
        .out_time       (out_time),
        .out_kind       (out_kind),
        .out_mobile     (out_mobile),
        .out_switch     (out_switch),
        .out_handle     (out_handle),
        .entry_count    (entry_count),
        .list_empty     (list_empty),
        .insert_dropped (insert_dropped),
        .removed_count  (removed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic entry_t ev_of(input logic [31:0] t, input logic [3:0] k,
                                     input logic [15:0] m, input logic [7:0] s,
                                     input logic [15:0] h);
        entry_t e;
        e.ev_time = t;
        e.kind    = k;
        e.mobile  = m;
        e.sw      = s;
        e.handle  = h;
        return e;
    endfunction

    // Builds an expected result by hand; the empty flag follows from the count.
    function automatic result_t res_of(input int pv, input entry_t e, input int cnt,
                                       input int drop, input int rem);
        result_t r;
        r.popped_valid   = 1'(pv);
        r.out_time       = e.ev_time;
        r.out_kind       = e.kind;
        r.out_mobile     = e.mobile;
        r.out_switch     = e.sw;
        r.out_handle     = e.handle;
        r.entry_count    = 7'(cnt);
        r.list_empty     = (cnt == 0);
        r.insert_dropped = 1'(drop);
        r.removed_count  = 7'(rem);
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input logic [1:0] fn, input entry_t ev,
                                    input logic typed, input result_t want);
        dir_row_t row;
        row.fn    = fn;
        row.ev    = ev;
        row.typed = typed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Applies one operation to the predicted queue and returns the result the
    // block must give for it.
    function automatic result_t queue_apply(input logic [1:0] fn, input entry_t ev);
        result_t r;
        entry_t  survivors[$];
        entry_t  head;
        int      pos;
        r = '0;
        case (fn)
            FUNC_INSERT:
            begin
                if (sched_q.size() >= DEPTH)
                begin
                    r.insert_dropped = 1'b1;
                end
                else
                begin
                    // Equal times go behind the ones already stored.
                    pos = 0;
                    while (pos < sched_q.size() && sched_q[pos].ev_time <= ev.ev_time)
                        pos++;
                    sched_q.insert(pos, ev);
                end
            end
            FUNC_POP:
            begin
                if (sched_q.size() != 0)
                begin
                    head = sched_q[0];
                    sched_q.delete(0);
                    r.popped_valid = 1'b1;
                    r.out_time     = head.ev_time;
                    r.out_kind     = head.kind;
                    r.out_mobile   = head.mobile;
                    r.out_switch   = head.sw;
                    r.out_handle   = head.handle;
                end
            end
            FUNC_REMOVE:
            begin
                // The handle takes no part in the match.
                foreach (sched_q[i])
                begin
                    if (sched_q[i].ev_time == ev.ev_time && sched_q[i].kind == ev.kind &&
                        sched_q[i].mobile == ev.mobile && sched_q[i].sw == ev.sw)
                        r.removed_count++;
                    else
                        survivors.insert(survivors.size(), sched_q[i]);
                end
                sched_q = survivors;
            end
            default: ;
        endcase
        r.entry_count = 7'(sched_q.size());
        r.list_empty  = (sched_q.size() == 0);
        return r;
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Draws the event fields of a random operation. Most removes aim at a stored
    // event, some of them with one field disturbed so that they just miss.
    function automatic entry_t pick_event(input logic [1:0] fn);
        entry_t e;
        int     idx;
        e = ev_of($urandom, 4'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        if (fn == FUNC_REMOVE && sched_q.size() != 0 && $urandom_range(0, 99) < 70)
        begin
            idx = $urandom_range(0, sched_q.size() - 1);
            e = sched_q[idx];
            e.handle = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: e.ev_time[$urandom_range(0, 31)] ^= 1'b1;
                    1: e.kind[$urandom_range(0, 3)] ^= 1'b1;
                    2: e.mobile[$urandom_range(0, 15)] ^= 1'b1;
                    default: e.sw[$urandom_range(0, 7)] ^= 1'b1;
                endcase
            end
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            e.ev_time = time_pool[$urandom_range(0, 3)];
            e.kind    = 4'($urandom_range(0, 1));
            e.mobile  = mob_pool[$urandom_range(0, 1)];
            e.sw      = sw_pool[$urandom_range(0, 1)];
        end
        return e;
    endfunction

    // Presents one operation beat and waits for it to be taken. The predictor
    // runs at acceptance; a typed expectation, where given, replaces its answer
    // in the store, but the predicted queue still advances.
    task automatic send_beat(input logic [1:0] fn, input entry_t ev, input logic typed,
                             input result_t want);
        int      gap;
        result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func         <= fn;
        event_time   <= ev.ev_time;
        event_kind   <= ev.kind;
        mobile_id    <= ev.mobile;
        switch_id    <= ev.sw;
        event_handle <= ev.handle;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = queue_apply(fn, ev);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // Holds the input idle until the block has answered every beat sent so far.
    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Result side: checks every accepted beat against the oldest expectation,
    // then stalls for a random number of cycles before taking the next one.
    initial
    begin : result_side
        int      hold;
        result_t want;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat expected none, actual count %0d",
                             $time, entry_count);
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    cmp_field("popped_valid", 32'(want.popped_valid), 32'(popped_valid));
                    cmp_field("out_time", want.out_time, out_time);
                    cmp_field("out_kind", 32'(want.out_kind), 32'(out_kind));
                    cmp_field("out_mobile", 32'(want.out_mobile), 32'(out_mobile));
                    cmp_field("out_switch", 32'(want.out_switch), 32'(out_switch));
                    cmp_field("out_handle", 32'(want.out_handle), 32'(out_handle));
                    cmp_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                    cmp_field("list_empty", 32'(want.list_empty), 32'(list_empty));
                    cmp_field("insert_dropped", 32'(want.insert_dropped),
                              32'(insert_dropped));
                    cmp_field("removed_count", 32'(want.removed_count),
                              32'(removed_count));
                end
                hold = quiet ? 0 : $urandom_range(0, 4);
                if (hold > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (hold - 1) @(negedge clk);
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: any stretch this long with no beat taken on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles = idle_cycles + 1;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_sorted_event_queue: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        entry_t      zero_ev;
        entry_t      max_ev;
        entry_t      key_a;
        entry_t      ev;
        phase_mode_t mode;
        logic [1:0]  fn;
        int          sent;
        int          len;
        int          extra;
        int          roll;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_INSERT;
        event_time   = '0;
        event_kind   = '0;
        mobile_id    = '0;
        switch_id    = '0;
        event_handle = '0;

        foreach (time_pool[i])
            time_pool[i] = $urandom;
        foreach (mob_pool[i])
            mob_pool[i] = 16'($urandom);
        foreach (sw_pool[i])
            sw_pool[i] = 8'($urandom);

        zero_ev = '0;
        max_ev  = ev_of('1, '1, '1, '1, '1);
        key_a   = ev_of(32'h0000_0100, 4'h3, 16'h1234, 8'h56, 16'h0001);

        // Directed table. It starts from the empty queue after reset; rows with typed
        // expectations cover the plain cases: empty pop, the unused code, a remove on an
        // empty queue, the all-ones and all-zeros events, a remove of two duplicates and a
        // miss, while the predictor checks arrival order among equal times.
        add_row(FUNC_POP, zero_ev, 1'b1, res_of(0, zero_ev, 0, 0, 0));
        add_row(FUNC_NOP, max_ev, 1'b1, res_of(0, zero_ev, 0, 0, 0));
        add_row(FUNC_REMOVE, zero_ev, 1'b1, res_of(0, zero_ev, 0, 0, 0));
        add_row(FUNC_INSERT, max_ev, 1'b1, res_of(0, zero_ev, 1, 0, 0));
        add_row(FUNC_INSERT, zero_ev, 1'b1, res_of(0, zero_ev, 2, 0, 0));
        add_row(FUNC_INSERT, key_a, 1'b1, res_of(0, zero_ev, 3, 0, 0));
        key_a.handle = 16'h0002;
        add_row(FUNC_INSERT, key_a, 1'b1, res_of(0, zero_ev, 4, 0, 0));
        add_row(FUNC_INSERT, ev_of(32'h100, 4'h3, 16'h1235, 8'h56, 16'h3), 1'b0, '0);
        add_row(FUNC_INSERT, ev_of(32'h100, 4'h2, 16'h1234, 8'h56, 16'h4), 1'b0, '0);
        add_row(FUNC_NOP, max_ev, 1'b1, res_of(0, zero_ev, 6, 0, 0));
        add_row(FUNC_POP, max_ev, 1'b1, res_of(1, zero_ev, 5, 0, 0));
        add_row(FUNC_REMOVE, key_a, 1'b1, res_of(0, zero_ev, 3, 0, 2));
        add_row(FUNC_REMOVE, key_a, 1'b1, res_of(0, zero_ev, 3, 0, 0));
        add_row(FUNC_REMOVE, ev_of(32'h100, 4'h3, 16'h1234, 8'h57, 16'h0), 1'b0, '0);
        add_row(FUNC_REMOVE, ev_of(32'h101, 4'h3, 16'h1235, 8'h56, 16'h0), 1'b0, '0);
        add_row(FUNC_POP, zero_ev, 1'b0, '0);
        add_row(FUNC_POP, zero_ev, 1'b0, '0);
        add_row(FUNC_POP, zero_ev, 1'b1, res_of(1, max_ev, 0, 0, 0));
        add_row(FUNC_POP, max_ev, 1'b1, res_of(0, zero_ev, 0, 0, 0));
        add_row(FUNC_INSERT, ev_of(32'h80, 4'h1, 16'h00FF, 8'h0F, 16'hA), 1'b0, '0);
        add_row(FUNC_INSERT, ev_of(32'h80, 4'h1, 16'h00FF, 8'h0F, 16'hB), 1'b0, '0);
        add_row(FUNC_INSERT, ev_of(32'h7F, 4'h1, 16'h00FF, 8'h0F, 16'hC), 1'b0, '0);
        add_row(FUNC_REMOVE, ev_of(32'h80, 4'h1, 16'h00FF, 8'h0F, 16'h0), 1'b0, '0);
        add_row(FUNC_POP, zero_ev, 1'b0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].fn, dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // Random part, in phases. Each phase has a bias: a mixed load, a fill that
        // runs into the full queue and keeps pushing so inserts get dropped, a
        // drain that empties it and pops past empty, and a phase heavy on removes.
        // Between phases the sender waits until every result is back.
        sent = 0;
        while (sent < RAND_BEATS)
        begin
            mode  = phase_mode_t'($urandom_range(0, 3));
            quiet = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(40, 120);
            extra = 0;
            while (mode == MODE_FILL ? extra < 8 : len > 0)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        fn = (roll < 90) ? FUNC_INSERT : FUNC_POP;
                    MODE_DRAIN:
                        fn = (roll < 80) ? FUNC_POP : (roll < 90) ? FUNC_INSERT :
                             (roll < 95) ? FUNC_REMOVE : FUNC_NOP;
                    MODE_PURGE:
                        fn = (roll < 50) ? FUNC_INSERT : (roll < 90) ? FUNC_REMOVE :
                             (roll < 95) ? FUNC_POP : FUNC_NOP;
                    default:
                        fn = (roll < 45) ? FUNC_INSERT : (roll < 75) ? FUNC_POP :
                             (roll < 95) ? FUNC_REMOVE : FUNC_NOP;
                endcase
                ev = pick_event(fn);
                send_beat(fn, ev, 1'b0, '0);
                sent++;
                len--;
                if (sched_q.size() == DEPTH)
                    extra++;
            end
            drain_results();
        end

        // Every expectation is met; leave room for a stray late result.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_sorted_event_queue: clean");
        else
            $display("tb_sorted_event_queue: errors");
        $finish;
    end

endmodule
